// ----- rtl/fgpm_pkg.sv -----
`timescale 1ns / 1ps

package fgpm_pkg;

	// Sample width of the audio lanes.
	localparam int SAMPLE_BITS = 24;

	// Configuration register widths.
	localparam int GAIN_W    = 16;
	localparam int PAN_W     = 16;
	localparam int ALPHA_W   = 16;
	localparam int STEP_W    = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;

	// State widths: gain Q2.30, pan Q1.30, mute level Q1.16.
	localparam int STATE_W = 32;
	localparam int LEVEL_W = 17;

	// Shared multiplier: signed A by signed B, full product.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Lane factor (Q.24) and pan-law accumulator widths.
	localparam int FACT_W = 28;
	localparam int ACC_W  = 64;
	localparam int Y_W    = PROD_W - 24;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_PAN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE_ON      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE_STEP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE  = 3'd5;

	// Reset values and fixed-point constants.
	localparam logic [GAIN_W-1:0]         TARGET_GAIN_RST = 16'd16384;
	localparam logic [ALPHA_W-1:0]        ALPHA_RST       = 16'd92;
	localparam logic [STEP_W-1:0]         STEP_RST        = 17'd137;
	localparam logic [STATE_W-1:0]        GAIN_UNITY      = 32'h4000_0000;
	localparam logic signed [STATE_W-1:0] Q30_ONE         = 32'sh4000_0000;
	localparam logic [LEVEL_W-1:0]        MUTE_FULL       = 17'h1_0000;
	localparam logic signed [ACC_W-1:0]   ACC_RND         = 64'sh0000_0008_0000_0000;

	// Operand selection codes of the shared multiplier.
	typedef logic [3:0] mul_sel_t;
	localparam mul_sel_t MS_DG = 4'd0;	// gain error times alpha
	localparam mul_sel_t MS_DP = 4'd1;	// pan error times alpha
	localparam mul_sel_t MS_SM = 4'd2;	// smoothed gain times mute level
	localparam mul_sel_t MS_LH = 4'd3;	// gain times left pan law, upper half
	localparam mul_sel_t MS_LL = 4'd4;	// gain times left pan law, lower half
	localparam mul_sel_t MS_RH = 4'd5;	// gain times right pan law, upper half
	localparam mul_sel_t MS_RL = 4'd6;	// gain times right pan law, lower half
	localparam mul_sel_t MS_XL = 4'd7;	// left sample times left factor
	localparam mul_sel_t MS_XR = 4'd8;	// right sample times right factor

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     cap_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     upd_gain;
		logic     upd_mute;
		logic     upd_pan;
		logic     ld_g;
		logic     ld_acc;
		logic     ld_fl;
		logic     ld_fr;
		logic     ld_yl;
		logic     ld_out;
	} fgpm_cmd_t;

endpackage

// ----- rtl/fgpm_ctrl.sv -----
`timescale 1ns / 1ps

module fgpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output fgpm_pkg::fgpm_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DG   = 4'd1;
	localparam logic [3:0] ST_DP   = 4'd2;
	localparam logic [3:0] ST_SM   = 4'd3;
	localparam logic [3:0] ST_GN   = 4'd4;
	localparam logic [3:0] ST_LH   = 4'd5;
	localparam logic [3:0] ST_LL   = 4'd6;
	localparam logic [3:0] ST_RH   = 4'd7;
	localparam logic [3:0] ST_RL   = 4'd8;
	localparam logic [3:0] ST_FR   = 4'd9;
	localparam logic [3:0] ST_XL   = 4'd10;
	localparam logic [3:0] ST_XR   = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	// The output register can take a new result when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Sequencer: at most one product of the shared multiplier per step.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = fgpm_pkg::MS_DG;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = ST_DG;
				end
			end
			ST_DG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_DG;
				state_d     = ST_DP;
			end
			ST_DP: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = fgpm_pkg::MS_DP;
				cmd.upd_gain = 1'b1;
				cmd.upd_mute = 1'b1;
				state_d      = ST_SM;
			end
			ST_SM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_SM;
				cmd.upd_pan = 1'b1;
				state_d     = ST_GN;
			end
			ST_GN: begin
				cmd.ld_g = 1'b1;
				state_d  = ST_LH;
			end
			ST_LH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_LH;
				state_d     = ST_LL;
			end
			ST_LL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_LL;
				cmd.ld_acc  = 1'b1;
				state_d     = ST_RH;
			end
			ST_RH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_RH;
				cmd.ld_fl   = 1'b1;
				state_d     = ST_RL;
			end
			ST_RL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_RL;
				cmd.ld_acc  = 1'b1;
				state_d     = ST_FR;
			end
			ST_FR: begin
				cmd.ld_fr = 1'b1;
				state_d   = ST_XL;
			end
			ST_XL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_XL;
				state_d     = ST_XR;
			end
			ST_XR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fgpm_pkg::MS_XR;
				cmd.ld_yl   = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/fgpm_dp.sv -----
`timescale 1ns / 1ps

module fgpm_dp (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  fgpm_pkg::fgpm_cmd_t                        cmd,
	input  logic                                       wr_en,
	input  logic [fgpm_pkg::CFG_IDX_W-1:0]             wr_index,
	input  logic [fgpm_pkg::CFG_W-1:0]                 wr_data,
	input  logic signed [fgpm_pkg::SAMPLE_BITS-1:0]    left_in,
	input  logic signed [fgpm_pkg::SAMPLE_BITS-1:0]    right_in,
	input  logic                                       last_in_block,
	output logic signed [fgpm_pkg::SAMPLE_BITS-1:0]    left_out,
	output logic signed [fgpm_pkg::SAMPLE_BITS-1:0]    right_out,
	output logic                                       last_out
);

	localparam int SB = fgpm_pkg::SAMPLE_BITS;

	// Configuration registers.
	logic [fgpm_pkg::GAIN_W-1:0]         tgain_q;
	logic signed [fgpm_pkg::PAN_W-1:0]   tpan_q;
	logic                                mute_on_q;
	logic [fgpm_pkg::ALPHA_W-1:0]        alpha_q;
	logic [fgpm_pkg::STEP_W-1:0]         step_q;
	logic                                stereo_q;

	// Smoothing state.
	logic [fgpm_pkg::STATE_W-1:0]        sg_q;
	logic signed [fgpm_pkg::STATE_W-1:0] sp_q;
	logic [fgpm_pkg::LEVEL_W-1:0]        ml_q;

	// Working registers.
	logic signed [SB-1:0]                     xl_q;
	logic signed [SB-1:0]                     xr_q;
	logic                                     last_q;
	logic signed [fgpm_pkg::PROD_W-1:0]       prod_q;
	logic signed [fgpm_pkg::ACC_W-1:0]        acc_q;
	logic [fgpm_pkg::STATE_W-1:0]             g_q;
	logic signed [fgpm_pkg::FACT_W-1:0]       fl_q;
	logic signed [fgpm_pkg::FACT_W-1:0]       fr_q;
	logic signed [SB-1:0]                     yl_q;
	logic signed [SB-1:0]                     left_out_q;
	logic signed [SB-1:0]                     right_out_q;
	logic                                     last_out_q;

	// Combinational nets.
	logic signed [fgpm_pkg::MUL_A_W-1:0]  diff_g;
	logic signed [fgpm_pkg::MUL_A_W-1:0]  diff_p;
	logic signed [fgpm_pkg::STATE_W-1:0]  pan_l;
	logic signed [fgpm_pkg::STATE_W-1:0]  pan_r;
	logic signed [fgpm_pkg::STATE_W-1:0]  pan_sel;
	logic signed [fgpm_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [fgpm_pkg::MUL_B_W-1:0]  mul_b;
	logic signed [fgpm_pkg::PROD_W-1:0]   prod_r16;
	logic [fgpm_pkg::STATE_W-1:0]         delta16;
	logic signed [fgpm_pkg::ACC_W-1:0]    fac_sum;
	logic signed [fgpm_pkg::FACT_W-1:0]   fact;
	logic signed [fgpm_pkg::PROD_W-1:0]   prod_r24;
	logic signed [fgpm_pkg::Y_W-1:0]      y_wide;
	logic signed [SB-1:0]                 y_sat;
	logic [fgpm_pkg::LEVEL_W:0]           ml_up;
	logic [fgpm_pkg::LEVEL_W-1:0]         ml_next;

	// Saturate a rounded lane value to the sample width.
	function automatic logic signed [SB-1:0] sat_lane(input logic signed [fgpm_pkg::Y_W-1:0] y);
		logic [fgpm_pkg::Y_W-SB:0] hi;
		logic signed [SB-1:0]      r;
		hi = y[fgpm_pkg::Y_W-1:SB-1];
		if (hi == '0 || hi == '1) begin
			r = y[SB-1:0];
		end else if (y[fgpm_pkg::Y_W-1]) begin
			r = {1'b1, {(SB-1){1'b0}}};
		end else begin
			r = {1'b0, {(SB-1){1'b1}}};
		end
		return r;
	endfunction

	// Errors between targets and smoothed values.
	assign diff_g = $signed({1'b0, tgain_q, 16'd0}) - $signed({1'b0, sg_q});
	assign diff_p = $signed({tpan_q[fgpm_pkg::PAN_W-1], tpan_q, 16'd0})
		- $signed({sp_q[fgpm_pkg::STATE_W-1], sp_q});

	// Pan law in Q1.30; a positive pan attenuates only the left side, a negative pan only the right; none in mono mode.
	always_comb begin
		if (!stereo_q || sp_q < 0) begin
			pan_l = fgpm_pkg::Q30_ONE;
		end else begin
			pan_l = fgpm_pkg::Q30_ONE - sp_q;
		end
		if (!stereo_q || sp_q > 0) begin
			pan_r = fgpm_pkg::Q30_ONE;
		end else begin
			pan_r = fgpm_pkg::Q30_ONE + sp_q;
		end
	end

	// Operand selection for the shared multiplier.
	// The upper half of the pan law carries its sign; the lower half is unsigned.
	always_comb begin
		if (cmd.mul_sel == fgpm_pkg::MS_LH || cmd.mul_sel == fgpm_pkg::MS_LL) begin
			pan_sel = pan_l;
		end else begin
			pan_sel = pan_r;
		end
		mul_a = $signed({1'b0, g_q});
		mul_b = '0;
		case (cmd.mul_sel)
			fgpm_pkg::MS_DG: begin
				mul_a = diff_g;
				mul_b = fgpm_pkg::MUL_B_W'(alpha_q);
			end
			fgpm_pkg::MS_DP: begin
				mul_a = diff_p;
				mul_b = fgpm_pkg::MUL_B_W'(alpha_q);
			end
			fgpm_pkg::MS_SM: begin
				mul_a = $signed({1'b0, sg_q});
				mul_b = fgpm_pkg::MUL_B_W'(ml_q);
			end
			fgpm_pkg::MS_LH, fgpm_pkg::MS_RH: begin
				mul_b = fgpm_pkg::MUL_B_W'($signed(pan_sel[fgpm_pkg::STATE_W-1:16]));
			end
			fgpm_pkg::MS_LL, fgpm_pkg::MS_RL: begin
				mul_b = fgpm_pkg::MUL_B_W'(pan_sel[15:0]);
			end
			fgpm_pkg::MS_XL: begin
				mul_a = fgpm_pkg::MUL_A_W'(fl_q);
				mul_b = fgpm_pkg::MUL_B_W'(xl_q);
			end
			fgpm_pkg::MS_XR: begin
				mul_a = fgpm_pkg::MUL_A_W'(fr_q);
				mul_b = fgpm_pkg::MUL_B_W'(xr_q);
			end
			default: begin
				mul_b = '0;
			end
		endcase
	end

	// Rounding of the registered product, half up.
	assign prod_r16 = prod_q + fgpm_pkg::PROD_W'(32768);
	assign delta16  = prod_r16[47:16];
	assign fac_sum  = acc_q + fgpm_pkg::ACC_W'(prod_q);
	assign fact     = fac_sum[fgpm_pkg::ACC_W-1:36];
	assign prod_r24 = prod_q + fgpm_pkg::PROD_W'(8388608);
	assign y_wide   = prod_r24[fgpm_pkg::PROD_W-1:24];
	assign y_sat    = sat_lane(y_wide);

	// Linear mute ramp toward silence or full level, without overshoot.
	assign ml_up = {1'b0, ml_q} + {1'b0, step_q};
	always_comb begin
		if (mute_on_q) begin
			ml_next = (ml_q > step_q) ? ml_q - step_q : '0;
		end else if (ml_up > {1'b0, fgpm_pkg::MUTE_FULL}) begin
			ml_next = fgpm_pkg::MUTE_FULL;
		end else begin
			ml_next = ml_up[fgpm_pkg::LEVEL_W-1:0];
		end
	end

	// Configuration and smoothing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgain_q   <= fgpm_pkg::TARGET_GAIN_RST;
			tpan_q    <= '0;
			mute_on_q <= 1'b0;
			alpha_q   <= fgpm_pkg::ALPHA_RST;
			step_q    <= fgpm_pkg::STEP_RST;
			stereo_q  <= 1'b1;
			sg_q      <= fgpm_pkg::GAIN_UNITY;
			sp_q      <= '0;
			ml_q      <= fgpm_pkg::MUTE_FULL;
		end else begin
			if (wr_en) begin
				case (wr_index)
					fgpm_pkg::REG_TARGET_GAIN:  tgain_q   <= wr_data[fgpm_pkg::GAIN_W-1:0];
					fgpm_pkg::REG_TARGET_PAN:   tpan_q    <= wr_data[fgpm_pkg::PAN_W-1:0];
					fgpm_pkg::REG_MUTE_ON:      mute_on_q <= wr_data[0];
					fgpm_pkg::REG_SMOOTH_ALPHA: alpha_q   <= wr_data[fgpm_pkg::ALPHA_W-1:0];
					fgpm_pkg::REG_MUTE_STEP:    step_q    <= wr_data[fgpm_pkg::STEP_W-1:0];
					fgpm_pkg::REG_STEREO_MODE:  stereo_q  <= wr_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.upd_gain) begin
				sg_q <= sg_q + delta16;
			end
			if (cmd.upd_pan) begin
				sp_q <= sp_q + $signed(delta16);
			end
			if (cmd.upd_mute) begin
				ml_q <= ml_next;
			end
		end
	end

	// Working registers of the frame.
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			xl_q   <= left_in;
			xr_q   <= right_in;
			last_q <= last_in_block;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.ld_g) begin
			g_q <= delta16;
		end
		if (cmd.ld_acc) begin
			acc_q <= (fgpm_pkg::ACC_W'(prod_q) <<< 16) + fgpm_pkg::ACC_RND;
		end
		if (cmd.ld_fl) begin
			fl_q <= fact;
		end
		if (cmd.ld_fr) begin
			fr_q <= fact;
		end
		if (cmd.ld_yl) begin
			yl_q <= y_sat;
		end
		if (cmd.ld_out) begin
			left_out_q  <= yl_q;
			right_out_q <= y_sat;
			last_out_q  <= last_q;
		end
	end

	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign last_out  = last_out_q;

endmodule

// ----- rtl/fader_gain_pan_mute.sv -----
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     left_in, right_in, last_in_block
// output    out_valid / out_ready   left_out, right_out, last_out
// config    wr_en                   wr_index, wr_data
//
// One frame is in work at a time: nine products pass one at a time through a single shared
// 33 by 24 bit multiplier, and a new frame is accepted only when the sequencer is idle.
// The result is loaded into the output register in the last step, ST_DONE.
// A result waiting on out_ready holds the sequencer in its last step only.
// Reset returns the smoothed gain to unity, the pan to centre and the mute level to full.

module fader_gain_pan_mute (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [fgpm_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [fgpm_pkg::SAMPLE_BITS-1:0] right_in,
	input  logic                                    last_in_block,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [fgpm_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [fgpm_pkg::SAMPLE_BITS-1:0] right_out,
	output logic                                    last_out,
	input  logic                                    wr_en,
	input  logic [fgpm_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [fgpm_pkg::CFG_W-1:0]              wr_data
);

	fgpm_pkg::fgpm_cmd_t cmd;

	// Sequencer and handshake control.
	fgpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Arithmetic, state and configuration registers.
	fgpm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.left_in       (left_in),
		.right_in      (right_in),
		.last_in_block (last_in_block),
		.left_out      (left_out),
		.right_out     (right_out),
		.last_out      (last_out)
	);

`ifndef SYNTHESIS
	// A finished result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!out_valid || out_ready))
		else $error("result loaded over a pending result");

	// Only one frame is in work at a time.
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while a frame is in work");

	// A loaded result is offered on the next cycle.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> out_valid)
		else $error("loaded result not presented");

	// Inputs are captured exactly when a request is accepted.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_in |-> (in_valid && in_ready))
		else $error("input captured without an accepted request");
`endif

endmodule
